### src/modbus_rtu_register_slave_core_defines.svh
// Assertion macros for the Modbus RTU register slave.
`ifndef MODBUS_RTU_REGISTER_SLAVE_CORE_DEFINES_SVH
`define MODBUS_RTU_REGISTER_SLAVE_CORE_DEFINES_SVH
`ifndef SYNTH
`define MRS_ASSERT_IMPL(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("mrs check failed");
`define MRS_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("mrs check failed");
`else
`define MRS_ASSERT_IMPL(lbl, a, c)
`define MRS_ASSERT_NEXT(lbl, a, c)
`endif
`endif

### src/mrs_pkg.sv
// Shared types and constants for the Modbus RTU register slave.
package mrs_pkg;
    localparam int HoldingCount = 64;
    localparam int InputCount   = 64;
    localparam int FrameBytes   = 256;
    localparam int MaxReadQty   = 29;
    localparam int HaW = $clog2(HoldingCount);
    localparam int IaW = $clog2(InputCount);
    localparam int FbW = $clog2(FrameBytes);
    localparam int LenW = FbW + 1;

    localparam logic [1:0] FUNC_RX    = 2'd0;
    localparam logic [1:0] FUNC_IWR   = 2'd1;
    localparam logic [1:0] FUNC_HRD   = 2'd2;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_CRC   = 3'd1;
    localparam logic [2:0] ST_ADDR  = 3'd2;
    localparam logic [2:0] ST_FUNC  = 3'd3;
    localparam logic [2:0] ST_RANGE = 3'd4;
    localparam logic [2:0] ST_LEN   = 3'd5;

    localparam logic [7:0] FC_RD_HOLD = 8'd3;
    localparam logic [7:0] FC_RD_IN   = 8'd4;
    localparam logic [7:0] FC_WR_ONE  = 8'd6;
    localparam logic [7:0] FC_WR_MULT = 8'd16;

    // command passed from front to back
    localparam logic [1:0] CMD_IWR   = 2'd0;
    localparam logic [1:0] CMD_HRD   = 2'd1;
    localparam logic [1:0] CMD_FRAME = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  rx_byte;
        logic        frame_end;
        logic [5:0]  reg_addr;
        logic [15:0] reg_value;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        tx_valid;
        logic        tx_last;
        logic [2:0]  status;
        logic [15:0] local_data;
    } res_t;

    function automatic logic [15:0] crc_add(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            x = x[0] ? ((x >> 1) ^ 16'hA001) : (x >> 1);
        end
        return x;
    endfunction
endpackage

### src/mrs_in_if.sv
// Input item channel.
interface mrs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  rx_byte;
    logic        frame_end;
    logic [5:0]  reg_addr;
    logic [15:0] reg_value;
    modport source (output valid, func, rx_byte, frame_end, reg_addr, reg_value,
                    input ready);
    modport sink (input valid, func, rx_byte, frame_end, reg_addr, reg_value,
                  output ready);
endinterface

### src/mrs_out_if.sv
// Result item channel.
interface mrs_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic        tx_last;
    logic [2:0]  status;
    logic [15:0] local_data;
    modport source (output valid, tx_byte, tx_valid, tx_last, status, local_data,
                    input ready);
    modport sink (input valid, tx_byte, tx_valid, tx_last, status, local_data,
                  output ready);
endinterface

### src/modbus_rtu_register_slave_core.sv
// Top level of the Modbus RTU register slave.
// Channels: in_ch carries items (func 0 frame byte with frame_end, func 1 local
// input register write, func 2 local holding register read); out_ch carries
// result items; slave_address_we/slave_address_wd set the slave address.
// A frame byte is buffered and folded into the running CRC when the back takes it;
// non-final bytes give no result. On the final byte the back reads header bytes
// from the frame buffer (one per cycle), checks the frame, writes any holding
// registers (two buffer reads per register), then streams the reply, one byte
// per cycle while the receiver is ready, ending with the CRC low then high byte.
// A read reply sends two bytes per register and pauses for each store read.
// Errors give one status result. A local read gives one result via the store read.
// After reset a clearing pass zeroes both register stores; the back takes no
// item during it, so at most two items wait in the front queue.
// A two-entry queue between front and back lets input items keep arriving
// while the back waits on a stalled receiver; the result register holds its
// item until it is taken.
module modbus_rtu_register_slave_core (
    input  logic        clk,
    input  logic        rst_n,
    mrs_in_if.sink      in_ch,
    mrs_out_if.source   out_ch,
    input  logic        slave_address_we,
    input  logic [7:0]  slave_address_wd
);
    logic          cmd_valid;
    logic          cmd_ready;
    mrs_pkg::cmd_t cmd;
    logic [7:0]    slave_address_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= 8'd1;
        end
        else if (slave_address_we)
        begin
            slave_address_reg <= slave_address_wd;
        end
    end

    mrs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    mrs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .slave_address (slave_address_reg),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .out_ch        (out_ch)
    );
endmodule

### src/mrs_front.sv
// Front: accepts items, drops unused codes, queues commands for the back.
`include "modbus_rtu_register_slave_core_defines.svh"
module mrs_front (
    input  logic               clk,
    input  logic               rst_n,
    mrs_in_if.sink             in_ch,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output mrs_pkg::cmd_t      cmd
);
    // two-entry queue
    mrs_pkg::cmd_t q_reg [2];
    logic [1:0]    cnt_reg, cnt_next;
    logic          wp_reg, rp_reg;
    logic          push, pop, keep;
    mrs_pkg::cmd_t c_in;

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign keep = (in_ch.func != 2'd3);
    assign push = in_ch.valid && in_ch.ready && keep;
    assign pop  = cmd_valid && cmd_ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd = q_reg[rp_reg];

    always_comb
    begin
        c_in.cmd = (in_ch.func == mrs_pkg::FUNC_RX) ? mrs_pkg::CMD_FRAME :
                   (in_ch.func == mrs_pkg::FUNC_IWR) ? mrs_pkg::CMD_IWR : mrs_pkg::CMD_HRD;
        c_in.rx_byte = in_ch.rx_byte;
        c_in.frame_end = in_ch.frame_end;
        c_in.reg_addr = in_ch.reg_addr;
        c_in.reg_value = in_ch.reg_value;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= c_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
        end
    end

    `MRS_ASSERT_IMPL(a_cnt_max, 1'b1, cnt_reg <= 2'd2)
    `MRS_ASSERT_NEXT(a_full_nopush, cnt_reg == 2'd2 && !pop, cnt_reg == 2'd2)
    `MRS_ASSERT_IMPL(a_ptr, cnt_reg == 2'd0 || cnt_reg == 2'd2, wp_reg == rp_reg)
endmodule

### src/mrs_back.sv
// Back: frame buffer, register stores, frame check and reply sequencing.
`include "modbus_rtu_register_slave_core_defines.svh"
module mrs_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    slave_address,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  mrs_pkg::cmd_t cmd,
    mrs_out_if.source     out_ch
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HDR0  = 4'd1;
    localparam logic [3:0] S_HDR1  = 4'd2;
    localparam logic [3:0] S_HDR2  = 4'd3;
    localparam logic [3:0] S_HDR3  = 4'd4;
    localparam logic [3:0] S_CHECK = 4'd5;
    localparam logic [3:0] S_WMR   = 4'd6;
    localparam logic [3:0] S_WMW   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;
    localparam logic [3:0] S_RD    = 4'd9;
    localparam logic [3:0] S_CRCL  = 4'd10;
    localparam logic [3:0] S_CRCH  = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;
    localparam logic [3:0] S_CLR   = 4'd13;
    localparam logic [3:0] S_HRD   = 4'd14;

    localparam int AW = (mrs_pkg::HaW > mrs_pkg::IaW) ? mrs_pkg::HaW : mrs_pkg::IaW;

    logic [7:0]  fbuf [mrs_pkg::FrameBytes];
    logic [15:0] hmem [mrs_pkg::HoldingCount];
    logic [15:0] imem [mrs_pkg::InputCount];

    logic [3:0]  st_reg;
    logic [mrs_pkg::LenW-1:0] len_reg;
    logic [15:0] crc_reg, tcrc_reg;
    logic [7:0]  fc_reg, bc_reg, b0_reg;
    logic [15:0] start_reg, qty_reg;
    logic [mrs_pkg::FbW-1:0] fa_reg;
    logic [7:0]  hi_reg;
    logic [6:0]  idx_reg;
    logic [AW:0] clr_reg;
    logic        clr_done_reg;
    logic [7:0]  fbq_reg;
    logic [15:0] hq_reg, iq_reg;
    logic [2:0]  ecnt_reg;
    logic        rdlo_reg;
    mrs_pkg::res_t res_reg;
    logic        rv_reg;
    logic [3:0]  ret_reg;

    logic [15:0] crc_new;
    logic [mrs_pkg::FbW-1:0] fb_raddr;
    logic [16:0] endq;
    logic [2:0]  chk;
    logic        take;

    assign out_ch.valid = rv_reg;
    assign out_ch.tx_byte = res_reg.tx_byte;
    assign out_ch.tx_valid = res_reg.tx_valid;
    assign out_ch.tx_last = res_reg.tx_last;
    assign out_ch.status = res_reg.status;
    assign out_ch.local_data = res_reg.local_data;

    assign cmd_ready = clr_done_reg && (st_reg == S_IDLE) && !rv_reg;
    assign take = cmd_valid && cmd_ready;
    assign crc_new = mrs_pkg::crc_add(crc_reg, cmd.rx_byte);
    assign endq = start_reg + qty_reg;

    always_comb
    begin
        chk = mrs_pkg::ST_OK;
        if (len_reg < mrs_pkg::LenW'(4) || len_reg > mrs_pkg::LenW'(mrs_pkg::FrameBytes))
        begin
            chk = mrs_pkg::ST_LEN;
        end
        else if (crc_reg != 16'd0)
        begin
            chk = mrs_pkg::ST_CRC;
        end
        else if (b0_reg != slave_address)
        begin
            chk = mrs_pkg::ST_ADDR;
        end
        else if (fc_reg != mrs_pkg::FC_RD_HOLD && fc_reg != mrs_pkg::FC_RD_IN &&
                 fc_reg != mrs_pkg::FC_WR_ONE && fc_reg != mrs_pkg::FC_WR_MULT)
        begin
            chk = mrs_pkg::ST_FUNC;
        end
        else if (fc_reg == mrs_pkg::FC_WR_MULT)
        begin
            if (len_reg < mrs_pkg::LenW'(9) ||
                {1'b0, len_reg} != (mrs_pkg::LenW+1)'(9) + (mrs_pkg::LenW+1)'(bc_reg))
            begin
                chk = mrs_pkg::ST_LEN;
            end
            else if (qty_reg < 16'd1 || qty_reg > 16'd123 ||
                     {8'd0, bc_reg} != {qty_reg[14:0], 1'b0} || qty_reg[15] ||
                     endq > 17'(mrs_pkg::HoldingCount))
            begin
                chk = mrs_pkg::ST_RANGE;
            end
        end
        else if (len_reg != mrs_pkg::LenW'(8))
        begin
            chk = mrs_pkg::ST_LEN;
        end
        else if (fc_reg == mrs_pkg::FC_WR_ONE)
        begin
            if (start_reg >= 16'(mrs_pkg::HoldingCount))
            begin
                chk = mrs_pkg::ST_RANGE;
            end
        end
        else if (qty_reg < 16'd1 || qty_reg > 16'(mrs_pkg::MaxReadQty) ||
                 endq > ((fc_reg == mrs_pkg::FC_RD_HOLD) ? 17'(mrs_pkg::HoldingCount)
                                                         : 17'(mrs_pkg::InputCount)))
        begin
            chk = mrs_pkg::ST_RANGE;
        end
    end

    // frame buffer read address, taken from fa_reg in every state
    always_comb
    begin
        fb_raddr = fa_reg;
    end

    always_ff @(posedge clk)
    begin
        fbq_reg <= fbuf[fb_raddr];
        if (take && cmd.cmd == mrs_pkg::CMD_FRAME &&
            len_reg < mrs_pkg::LenW'(mrs_pkg::FrameBytes))
        begin
            fbuf[len_reg[mrs_pkg::FbW-1:0]] <= cmd.rx_byte;
        end
    end

    logic        hwe;
    logic [mrs_pkg::HaW-1:0] hwa;
    logic [15:0] hwd;
    logic [mrs_pkg::HaW-1:0] hra;
    logic        iwe;
    logic [mrs_pkg::IaW-1:0] iwa;
    logic [15:0] iwd;
    logic [mrs_pkg::IaW-1:0] ira;

    always_comb
    begin
        hwe = 1'b0;
        hwa = start_reg[mrs_pkg::HaW-1:0];
        hwd = qty_reg;
        iwe = 1'b0;
        iwa = cmd.reg_addr[mrs_pkg::IaW-1:0];
        iwd = cmd.reg_value;
        if (!clr_done_reg)
        begin
            hwe = 1'b1;
            hwa = clr_reg[mrs_pkg::HaW-1:0];
            hwd = 16'd0;
            iwe = 1'b1;
            iwa = clr_reg[mrs_pkg::IaW-1:0];
            iwd = 16'd0;
        end
        else
        begin
            if (st_reg == S_CHECK && chk == mrs_pkg::ST_OK && fc_reg == mrs_pkg::FC_WR_ONE)
            begin
                hwe = 1'b1;
            end
            if (st_reg == S_WMW)
            begin
                hwe = 1'b1;
                hwa = start_reg[mrs_pkg::HaW-1:0];
                hwd = {hi_reg, fbq_reg};
            end
            iwe = take && cmd.cmd == mrs_pkg::CMD_IWR &&
                  {1'b0, cmd.reg_addr} < 7'(mrs_pkg::InputCount);
        end
        hra = (st_reg == S_IDLE) ? cmd.reg_addr[mrs_pkg::HaW-1:0]
                                 : start_reg[mrs_pkg::HaW-1:0];
        ira = start_reg[mrs_pkg::IaW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (hwe)
        begin
            hmem[hwa] <= hwd;
        end
        if (iwe)
        begin
            imem[iwa] <= iwd;
        end
        hq_reg <= hmem[hra];
        iq_reg <= imem[ira];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_CLR;
            len_reg <= '0;
            crc_reg <= 16'hFFFF;
            clr_reg <= '0;
            clr_done_reg <= 1'b0;
            rv_reg <= 1'b0;
            ret_reg <= S_IDLE;
        end
        else
        begin
            unique case (st_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'((1 << AW) - 1))
                    begin
                        clr_done_reg <= 1'b1;
                        st_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (take)
                    begin
                        unique case (cmd.cmd)
                            mrs_pkg::CMD_HRD:
                            begin
                                st_reg <= S_HRD;
                            end
                            mrs_pkg::CMD_FRAME:
                            begin
                                if (len_reg <= mrs_pkg::LenW'(mrs_pkg::FrameBytes))
                                begin
                                    len_reg <= len_reg + 1'b1;
                                end
                                crc_reg <= crc_new;
                                if (cmd.frame_end)
                                begin
                                    st_reg <= S_HDR0;
                                    fa_reg <= '0;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_HRD:
                begin
                    res_reg <= '{tx_byte: 8'd0, tx_valid: 1'b0, tx_last: 1'b1,
                                 status: mrs_pkg::ST_OK, local_data: hq_reg};
                    rv_reg <= 1'b1;
                    st_reg <= S_OUT;
                    ret_reg <= S_IDLE;
                end
                S_HDR0:
                begin
                    // buffer reads are registered; data follows the address in the next cycle
                    fa_reg <= mrs_pkg::FbW'(1);
                    st_reg <= S_HDR1;
                    ecnt_reg <= 3'd0;
                end
                S_HDR1:
                begin
                    ecnt_reg <= ecnt_reg + 1'b1;
                    fa_reg <= fa_reg + 1'b1;
                    unique case (ecnt_reg)
                        3'd0: b0_reg <= fbq_reg;
                        3'd1: fc_reg <= fbq_reg;
                        3'd2: start_reg[15:8] <= fbq_reg;
                        3'd3: start_reg[7:0] <= fbq_reg;
                        3'd4: qty_reg[15:8] <= fbq_reg;
                        3'd5: qty_reg[7:0] <= fbq_reg;
                        3'd6:
                        begin
                            bc_reg <= fbq_reg;
                            st_reg <= S_CHECK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_CHECK:
                begin
                    len_reg <= '0;
                    crc_reg <= 16'hFFFF;
                    if (chk != mrs_pkg::ST_OK)
                    begin
                        res_reg <= '{tx_byte: 8'd0, tx_valid: 1'b0, tx_last: 1'b1,
                                     status: chk, local_data: 16'd0};
                        rv_reg <= 1'b1;
                        st_reg <= S_OUT;
                        ret_reg <= S_IDLE;
                    end
                    else
                    begin
                        tcrc_reg <= 16'hFFFF;
                        ecnt_reg <= 3'd0;
                        fa_reg <= mrs_pkg::FbW'(7);
                        idx_reg <= '0;
                        st_reg <= (fc_reg == mrs_pkg::FC_WR_MULT) ? S_HDR2 : S_EMIT;
                    end
                end
                S_HDR2:
                begin
                    // address 7 issued; data next cycle
                    fa_reg <= fa_reg + 1'b1;
                    st_reg <= S_WMR;
                end
                S_WMR:
                begin
                    hi_reg <= fbq_reg;
                    fa_reg <= fa_reg + 1'b1;
                    st_reg <= S_WMW;
                end
                S_WMW:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    fa_reg <= fa_reg + 1'b1;
                    if (16'({idx_reg + 1'b1}) == qty_reg)
                    begin
                        start_reg <= start_reg - {9'd0, idx_reg};
                        st_reg <= S_EMIT;
                    end
                    else
                    begin
                        start_reg <= start_reg + 1'b1;
                        st_reg <= S_WMR;
                    end
                end
                S_EMIT:
                begin
                    // header: addr, fc, then 4 echo bytes or byte count
                    if (!rv_reg || out_ch.ready)
                    begin
                        logic [7:0] b;
                        b = 8'd0;
                        unique case (ecnt_reg)
                            3'd0: b = b0_reg;
                            3'd1: b = fc_reg;
                            3'd2: b = (fc_reg == mrs_pkg::FC_RD_HOLD || fc_reg == mrs_pkg::FC_RD_IN)
                                      ? {qty_reg[6:0], 1'b0} : start_reg[15:8];
                            3'd3: b = start_reg[7:0];
                            3'd4: b = qty_reg[15:8];
                            3'd5: b = qty_reg[7:0];
                            default: b = 8'd0;
                        endcase
                        res_reg <= '{tx_byte: b, tx_valid: 1'b1, tx_last: 1'b0,
                                     status: mrs_pkg::ST_OK, local_data: 16'd0};
                        rv_reg <= 1'b1;
                        tcrc_reg <= mrs_pkg::crc_add(tcrc_reg, b);
                        ecnt_reg <= ecnt_reg + 1'b1;
                        if ((fc_reg == mrs_pkg::FC_RD_HOLD || fc_reg == mrs_pkg::FC_RD_IN)
                            && ecnt_reg == 3'd2)
                        begin
                            idx_reg <= '0;
                            rdlo_reg <= 1'b0;
                            st_reg <= S_HDR3;
                        end
                        else if (ecnt_reg == 3'd5)
                        begin
                            st_reg <= S_CRCL;
                        end
                    end
                end
                S_HDR3:
                begin
                    // wait in this state for the registered store read of start_reg
                    if (out_ch.ready)
                    begin
                        rv_reg <= 1'b0;
                    end
                    st_reg <= S_RD;
                end
                S_RD:
                begin
                    if (!rv_reg || out_ch.ready)
                    begin
                        logic [15:0] v;
                        logic [7:0]  b;
                        v = (fc_reg == mrs_pkg::FC_RD_HOLD) ? hq_reg : iq_reg;
                        b = rdlo_reg ? v[7:0] : v[15:8];
                        res_reg <= '{tx_byte: b, tx_valid: 1'b1, tx_last: 1'b0,
                                     status: mrs_pkg::ST_OK, local_data: 16'd0};
                        rv_reg <= 1'b1;
                        tcrc_reg <= mrs_pkg::crc_add(tcrc_reg, b);
                        rdlo_reg <= ~rdlo_reg;
                        if (rdlo_reg)
                        begin
                            idx_reg <= idx_reg + 1'b1;
                            start_reg <= start_reg + 1'b1;
                            if (16'({idx_reg + 1'b1}) == qty_reg)
                            begin
                                st_reg <= S_CRCL;
                            end
                            else
                            begin
                                st_reg <= S_HDR3;
                            end
                        end
                    end
                end
                S_CRCL:
                begin
                    if (!rv_reg || out_ch.ready)
                    begin
                        res_reg <= '{tx_byte: tcrc_reg[7:0], tx_valid: 1'b1, tx_last: 1'b0,
                                     status: mrs_pkg::ST_OK, local_data: 16'd0};
                        rv_reg <= 1'b1;
                        st_reg <= S_CRCH;
                    end
                end
                S_CRCH:
                begin
                    if (!rv_reg || out_ch.ready)
                    begin
                        res_reg <= '{tx_byte: tcrc_reg[15:8], tx_valid: 1'b1, tx_last: 1'b1,
                                     status: mrs_pkg::ST_OK, local_data: 16'd0};
                        rv_reg <= 1'b1;
                        st_reg <= S_OUT;
                        ret_reg <= S_IDLE;
                    end
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                    begin
                        rv_reg <= 1'b0;
                        st_reg <= ret_reg;
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

    `MRS_ASSERT_IMPL(a_no_take_busy, take, st_reg == S_IDLE && !rv_reg)
    `MRS_ASSERT_IMPL(a_len_cap, 1'b1, len_reg <= mrs_pkg::LenW'(mrs_pkg::FrameBytes + 1))
    `MRS_ASSERT_NEXT(a_hold_out, rv_reg && !out_ch.ready, rv_reg && $stable(res_reg))
    `MRS_ASSERT_IMPL(a_clr_block, !clr_done_reg, !cmd_ready)
endmodule
